// File: sv/pbwa_pkg.sv
`default_nettype none
package pbwa_pkg;

  localparam int unsigned ADDR_W        = 64;
  localparam int unsigned WORD_W        = 32;
  localparam int unsigned SLOTS_W       = 2;
  localparam int unsigned CFG_IDX_W     = 1;
  localparam int unsigned QUEUE_DEPTH   = 2;

  // Block sizes are powers of two, so the pointers only keep the block number.
  localparam int unsigned MEM_ALIGN_BITS = 22;
  localparam int unsigned IO_ALIGN_BITS  = 6;
  localparam int unsigned MEM_BLK_W      = ADDR_W - MEM_ALIGN_BITS;
  localparam int unsigned IO_BLK_W       = ADDR_W - IO_ALIGN_BITS;

  localparam logic [ADDR_W-1:0] MEM_ROUND = ADDR_W'((64'd1 << MEM_ALIGN_BITS) - 64'd1);
  localparam logic [ADDR_W-1:0] IO_ROUND  = ADDR_W'((64'd1 << IO_ALIGN_BITS) - 64'd1);

  // Reset pools, already block aligned.
  localparam logic [ADDR_W-1:0] MEM_POOL_RESET = 64'h0000_0000_1000_0000;
  localparam logic [ADDR_W-1:0] IO_POOL_RESET  = 64'h0000_0000_0000_1000;
  localparam logic [MEM_BLK_W-1:0] MEM_BLK_RESET = MEM_POOL_RESET[ADDR_W-1:MEM_ALIGN_BITS];
  localparam logic [IO_BLK_W-1:0]  IO_BLK_RESET  = IO_POOL_RESET[ADDR_W-1:IO_ALIGN_BITS];

  localparam logic [WORD_W-1:0] BAR_ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [1:0]        MEM_TYPE_64  = 2'b10;

  localparam logic [SLOTS_W-1:0] SLOTS_ONE = 2'd1;
  localparam logic [SLOTS_W-1:0] SLOTS_TWO = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MEM_POOL_BASE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_IO_POOL_BASE  = 1'b1;

  typedef enum logic [2:0] {
    OUT_UNPOPULATED = 3'd0,
    OUT_ALREADY     = 3'd1,
    OUT_IO          = 3'd2,
    OUT_MEM32       = 3'd3,
    OUT_MEM64       = 3'd4
  } outcome_t;

  typedef struct packed {
    outcome_t           kind;
    logic [SLOTS_W-1:0] slots;
  } req_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [ADDR_W-1:0]    data;
  } cfg_wr_t;

endpackage
`default_nettype wire

// File: sv/pbwa_front.sv
`default_nettype none
module pbwa_front
  import pbwa_pkg::*;
(
  input  wire logic              in_tvalid,
  input  wire logic [WORD_W-1:0] bar_low_word,
  input  wire logic [WORD_W-1:0] bar_high_word,
  input  wire logic              q_full,
  output logic                   in_tready,
  output logic                   push,
  output req_t                   req
);

  logic is_io;
  logic is_64;
  logic mem_taken;

  assign in_tready = !q_full;
  assign push      = in_tvalid && !q_full;

  assign is_io     = bar_low_word[0];
  assign is_64     = !is_io && (bar_low_word[2:1] == MEM_TYPE_64);
  assign mem_taken = (bar_low_word[WORD_W-1:4] != '0);

  always_comb begin
    req.kind  = OUT_ALREADY;
    req.slots = SLOTS_ONE;
    if (bar_low_word == BAR_ALL_ONES) begin
      req.kind = OUT_UNPOPULATED;
    end else if (is_64) begin
      req.slots = SLOTS_TWO;
      // The high word is part of the address only for the 64-bit type.
      if (!mem_taken && (bar_high_word == '0)) begin
        req.kind = OUT_MEM64;
      end
    end else if (is_io) begin
      if (bar_low_word[WORD_W-1:2] == '0) begin
        req.kind = OUT_IO;
      end
    end else if (!mem_taken) begin
      req.kind = OUT_MEM32;
    end
  end

endmodule
`default_nettype wire

// File: sv/pbwa_queue.sv
`default_nettype none
module pbwa_queue
  import pbwa_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire req_t push_req,
  input  wire logic pop,
  output logic      full,
  output logic      not_empty,
  output req_t      head
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  req_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    logic [PW-1:0] r;
    if (p == PW'(DEPTH - 1)) r = '0;
    else                     r = p + PW'(1);
    return r;
  endfunction

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop)      count_nxt = count_r + CW'(1);
    else if (pop && !push) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && full && !pop) |=> (count_r == CW'(DEPTH)))
    else $error("queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> not_empty)
    else $error("queue popped while empty");
  a_full_blocks_push: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("queue accepted a request while full");
`endif

endmodule
`default_nettype wire

// File: sv/pbwa_back.sv
`default_nettype none
module pbwa_back
  import pbwa_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire cfg_wr_t            cfg,
  input  wire logic               q_not_empty,
  input  wire req_t               q_head,
  output logic                    pop,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output outcome_t                outcome,
  output logic [SLOTS_W-1:0]      slots_used,
  output logic [WORD_W-1:0]       write_low_word,
  output logic [WORD_W-1:0]       write_high_word
);

  // Pointers hold the next free block number; a written pool base is rounded
  // up once here so that each request only needs an increment.
  logic [MEM_BLK_W-1:0] mem_blk_r, mem_blk_nxt;
  logic [IO_BLK_W-1:0]  io_blk_r, io_blk_nxt;
  logic [ADDR_W-1:0]    mem_cfg_sum;
  logic [ADDR_W-1:0]    io_cfg_sum;
  logic [ADDR_W-1:0]    mem_addr;
  logic [ADDR_W-1:0]    io_addr;

  logic                 out_valid_r, out_valid_nxt;
  outcome_t             outcome_r, outcome_nxt;
  logic [SLOTS_W-1:0]   slots_r, slots_nxt;
  logic [WORD_W-1:0]    low_r, low_nxt;
  logic [WORD_W-1:0]    high_r, high_nxt;

  assign pop = q_not_empty && (!out_valid_r || out_tready);

  assign mem_cfg_sum = cfg.data + MEM_ROUND;
  assign io_cfg_sum  = cfg.data + IO_ROUND;
  assign mem_addr    = {mem_blk_r, MEM_ALIGN_BITS'(0)};
  assign io_addr     = {io_blk_r, IO_ALIGN_BITS'(0)};

  always_comb begin
    mem_blk_nxt = mem_blk_r;
    io_blk_nxt  = io_blk_r;
    outcome_nxt = q_head.kind;
    slots_nxt   = q_head.slots;
    low_nxt     = '0;
    high_nxt    = '0;
    if (pop) begin
      unique case (q_head.kind)
        OUT_IO: begin
          low_nxt    = io_addr[WORD_W-1:0] | WORD_W'(1);
          io_blk_nxt = io_blk_r + IO_BLK_W'(1);
        end
        OUT_MEM32: begin
          low_nxt     = mem_addr[WORD_W-1:0];
          mem_blk_nxt = mem_blk_r + MEM_BLK_W'(1);
        end
        OUT_MEM64: begin
          low_nxt     = mem_addr[WORD_W-1:0];
          high_nxt    = mem_addr[ADDR_W-1:WORD_W];
          mem_blk_nxt = mem_blk_r + MEM_BLK_W'(1);
        end
        default: begin
        end
      endcase
    end
    if (cfg.en) begin
      unique case (cfg.idx)
        REG_MEM_POOL_BASE: mem_blk_nxt = mem_cfg_sum[ADDR_W-1:MEM_ALIGN_BITS];
        REG_IO_POOL_BASE:  io_blk_nxt  = io_cfg_sum[ADDR_W-1:IO_ALIGN_BITS];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop)             out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mem_blk_r   <= MEM_BLK_RESET;
      io_blk_r    <= IO_BLK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      mem_blk_r   <= mem_blk_nxt;
      io_blk_r    <= io_blk_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      outcome_r <= outcome_nxt;
      slots_r   <= slots_nxt;
      low_r     <= low_nxt;
      high_r    <= high_nxt;
    end
  end

  assign out_tvalid      = out_valid_r;
  assign outcome         = outcome_r;
  assign slots_used      = slots_r;
  assign write_low_word  = low_r;
  assign write_high_word = high_r;

`ifndef SYNTHESIS
  a_io_ptr_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && (q_head.kind == OUT_IO)) && !(cfg.en && (cfg.idx == REG_IO_POOL_BASE))
    |=> $stable(io_blk_r))
    else $error("io pointer moved without an io request");
  a_mem_ptr_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && ((q_head.kind == OUT_MEM32) || (q_head.kind == OUT_MEM64)))
    && !(cfg.en && (cfg.idx == REG_MEM_POOL_BASE))
    |=> $stable(mem_blk_r))
    else $error("memory pointer moved without a memory request");
  a_io_marks_space: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && (q_head.kind == OUT_IO)) |=> (out_tvalid && low_r[0] && (high_r == '0)))
    else $error("io result lacks the space bit");
`endif

endmodule
`default_nettype wire

// File: sv/pci_bar_window_assigner.sv
`default_nettype none
// An accepted request is written into a queue slot, then popped into the output register and offered there.
// Throughput: one request per cycle while out_tready does not stall the output.
// A two-entry queue between classification and assignment absorbs output stalls.
// Reset (rst_n low, synchronous) empties the queue, drops the output and loads the
// pointers with the pool reset values 0x10000000 and 0x1000; no clearing pass.
module pci_bar_window_assigner
  import pbwa_pkg::*;
#(
  parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  // bar_low_word[31:0], bar_high_word[63:32]
  input  wire logic [63:0]          in_tdata,
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  // slots_used[1:0], write_low_word[33:2], write_high_word[65:34], zero pad [71:66]
  output logic [71:0]               out_tdata,
  // outcome[2:0]
  output logic [2:0]                out_tuser,
  input  wire logic                 cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ADDR_W-1:0]    cfg_wdata
);

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_not_empty;
  req_t               front_req;
  req_t               q_head;
  cfg_wr_t            cfg;
  outcome_t           outcome;
  logic [SLOTS_W-1:0] slots_used;
  logic [WORD_W-1:0]  write_low_word;
  logic [WORD_W-1:0]  write_high_word;

  assign cfg.en   = cfg_wr_en;
  assign cfg.idx  = cfg_index;
  assign cfg.data = cfg_wdata;

  pbwa_front u_front (
    .in_tvalid     (in_tvalid),
    .bar_low_word  (in_tdata[31:0]),
    .bar_high_word (in_tdata[63:32]),
    .q_full        (q_full),
    .in_tready     (in_tready),
    .push          (push),
    .req           (front_req)
  );

  pbwa_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_req  (front_req),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  pbwa_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg),
    .q_not_empty     (q_not_empty),
    .q_head          (q_head),
    .pop             (pop),
    .out_tready      (out_tready),
    .out_tvalid      (out_tvalid),
    .outcome         (outcome),
    .slots_used      (slots_used),
    .write_low_word  (write_low_word),
    .write_high_word (write_high_word)
  );

  assign out_tdata = {6'd0, write_high_word, write_low_word, slots_used};
  assign out_tuser = outcome;

endmodule
`default_nettype wire
